/* hw/rtl/distinct_window_counter_defines.svh */
// Assertion macros shared by the distinct window counter RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef DISTINCT_WINDOW_COUNTER_DEFINES_SVH
`define DISTINCT_WINDOW_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dwc_pkg.sv */
// Package for the distinct window counter: sizes and shared types.
// Depends on nothing; used by the cell and the top level.
`default_nettype none

package dwc_pkg;

  // Depth of the value history and width of the compared value.
  localparam int WINDOW_MAX = 64;
  localparam int VALUE_BITS = 32;

  // Run length and distance hold 0..WINDOW_MAX.
  localparam int DIST_W  = $clog2(WINDOW_MAX + 1);
  localparam int CFG_W   = 7;
  localparam int COUNT_W = 32;
  localparam int CMP_W   = (DIST_W > CFG_W) ? DIST_W : CFG_W;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [CFG_W-1:0]      cfg_t;
  typedef logic [COUNT_W-1:0]    count_t;

endpackage

`default_nettype wire

/* hw/rtl/dwc_cell.sv */
// One cell of the value history chain: holds one value, passes it on and
// compares it with the incoming value. Depends on dwc_pkg.
`default_nettype none

module dwc_cell
  import dwc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   shift_en,
  input  wire value_t shift_in,
  input  wire value_t probe,
  input  wire logic   in_run,
  output value_t      data_out,
  output logic        hit
);

  value_t data_r;
  logic   hit_r;

  // On each beat the cell compares its held value with the new one, then
  // takes shift_in: the value of its neighbor nearer the head of the chain, or the new value at the head.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      hit_r  <= in_run && (data_r == probe);
      data_r <= shift_in;
    end
  end

  assign data_out = data_r;
  assign hit      = hit_r;

endmodule

`default_nettype wire

/* hw/rtl/distinct_window_counter.sv */
// Distinct window counter: each stream value enters a chain of WINDOW_MAX
// compare cells. When an item is accepted the cells compare the new value
// with the stored history and register a hit; then, while busy, the hits
// fold into the duplicate-free run length and the window count. The next
// compare needs that updated run length, so the input stalls while busy and
// takes no new beat until the fold is done. The count is sent on the beat
// marked last. A held result stalls only the fold of a later last beat, and
// the input waits until that fold is done.
// Depends on dwc_pkg, dwc_cell and distinct_window_counter_defines.svh.
`default_nettype none
`include "distinct_window_counter_defines.svh"

module distinct_window_counter
  import dwc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [CFG_W-1:0]   cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [COUNT_W-1:0]      out_window_count
);

  cfg_t   window_len_r;
  dist_t  run_r, run_nxt;
  count_t total_r, total_nxt;
  logic   busy_r;
  logic   last_r;
  logic   out_valid_r;
  count_t out_count_r;

  value_t probe;
  logic   in_accept;
  logic   done;
  value_t chain [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] hit;
  logic [WINDOW_MAX-1:0] in_run;
  dist_t  hit_dist;
  logic   hit_any;
  dist_t  run_inc;
  cfg_t   need;

  assign probe     = value_t'(in_value[VALUE_BITS-1:0]);
  assign in_stall  = busy_r;
  assign in_accept = in_valid && !busy_r;
  // The fold waits only when a last item meets a full result register.
  assign done      = busy_r && !(last_r && out_valid_r && out_stall);

  // Window length register, written at any time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= cfg_t'(1);
    end else if (cfg_wr_en) begin
      window_len_r <= cfg_wr_data;
    end
  end

  // Chain of compare cells; cell i holds the value i+1 items back.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign in_run[i] = dist_t'(i) < run_r;
    if (i == 0) begin : g_head
      dwc_cell u_cell (
        .clk      (clk),
        .shift_en (in_accept),
        .shift_in (probe),
        .probe    (probe),
        .in_run   (in_run[i]),
        .data_out (chain[i]),
        .hit      (hit[i])
      );
    end else begin : g_body
      dwc_cell u_cell (
        .clk      (clk),
        .shift_en (in_accept),
        .shift_in (chain[i-1]),
        .probe    (probe),
        .in_run   (in_run[i]),
        .data_out (chain[i]),
        .hit      (hit[i])
      );
    end
  end

  // Values inside the run are all distinct, so at most one cell hits and
  // its distance is an OR of the hit cells' distances.
  always_comb begin
    hit_dist = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (hit[i]) begin
        hit_dist = hit_dist | dist_t'(i + 1);
      end
    end
  end

  assign hit_any = |hit;
  assign run_inc = (run_r == dist_t'(WINDOW_MAX)) ? run_r : run_r + dist_t'(1);
  assign need    = (window_len_r == '0) ? cfg_t'(1) : window_len_r;

  // Run length and window count after the item, taken in the fold.
  always_comb begin
    run_nxt   = hit_any ? hit_dist : run_inc;
    total_nxt = total_r;
    if ((CMP_W'(run_nxt) >= CMP_W'(need)) && (total_r != '1)) begin
      total_nxt = total_r + count_t'(1);
    end
  end

  // Item sequencing, stream state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      last_r      <= 1'b0;
      run_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result may replace one that leaves at the same edge.
      if (done && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept) begin
        busy_r <= 1'b1;
        last_r <= in_last;
      end else if (done) begin
        busy_r <= 1'b0;
        if (last_r) begin
          run_r       <= '0;
          total_r     <= '0;
          out_count_r <= total_nxt;
        end else begin
          run_r   <= run_nxt;
          total_r <= total_nxt;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_count = out_count_r;

  // Checks on the run tracking and item sequencing.
  `DWC_ASSERT_IMP(a_run_cap, clk, rst_n, 1'b1, run_r <= dist_t'(WINDOW_MAX),
    "run length above the history depth")
  `DWC_ASSERT_IMP(a_single_hit, clk, rst_n, busy_r, $onehot0(hit),
    "more than one cell hit inside the run")
  `DWC_ASSERT_IMP(a_hit_in_run, clk, rst_n, busy_r && hit_any, hit_dist <= run_r,
    "hit distance beyond the current run")
  `DWC_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_accept, busy_r && !in_stall == 1'b0,
    "accepted beat did not enter the fold cycle")
  `DWC_ASSERT_NEXT(a_last_clears, clk, rst_n, done && last_r,
    out_valid_r && run_r == '0 && total_r == '0, "last beat did not emit and clear")

endmodule

`default_nettype wire
